/* rtl/qbp_pkg.sv */
// ----------------------------------------------------------------------------
// qbp_pkg
// Shared types, widths and helper functions for the quantizing bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package qbp_pkg;

   // Field and register widths.
   localparam int SAMPLE_W   = 20;
   localparam int FRAC_BITS  = 16;
   localparam int CLAMP_W    = FRAC_BITS + 1;
   localparam int CODE_W     = 8;
   localparam int PROD_W     = CLAMP_W + CODE_W;
   localparam int WORD_W     = 32;
   localparam int FILL_W     = 5;
   localparam int TOTAL_W    = FILL_W + 1;
   localparam int BPV_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Code width limits and register reset values.
   localparam logic [BPV_W-1:0] BPV_MIN   = 4'd2;
   localparam logic [BPV_W-1:0] BPV_MAX   = 4'd8;
   localparam logic [BPV_W-1:0] BPV_RESET = 4'd8;

   // Output queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BITS_PER_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIG_ENDIAN     = 2'd1;

   // One queued result word.
   typedef struct packed {
      logic              last;
      logic [WORD_W-1:0] word;
   } entry_type;

   // Up to two result words produced by one item; slot 1 only follows slot 0.
   typedef struct packed {
      logic      push0;
      entry_type entry0;
      logic      push1;
      entry_type entry1;
   } push_type;

   // Packer status, for checking.
   typedef struct packed {
      logic [FILL_W-1:0] filled;
   } pack_status_type;

   // Output queue status.
   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

   // Applies the configured byte order to a packed word.
   function automatic logic [WORD_W-1:0] order_word(input logic [WORD_W-1:0] w,
                                                    input logic big);
      logic [WORD_W-1:0] r;
      if (big) begin
         r = {w[7:0], w[15:8], w[23:16], w[31:24]};
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/quantize_bit_packer.sv */
// ----------------------------------------------------------------------------
// quantize_bit_packer
// Quantizes fixed-point samples to 2..8-bit codes and packs them LSB first
// into 32-bit words in the configured byte order.
// ----------------------------------------------------------------------------
// A sample is held in the input register, then packed; a word that it completes
// is written into the four-entry result queue and presented from there.
// Throughput: one sample per cycle; the queue drains one word per cycle when
// rsp_stall is low; the input register holds with fewer than two entries free.
// Reset: synchronous; clears the accumulator and the queue, and sets the
// code width to 8 bits and the byte order to little endian.
`default_nettype none

module quantize_bit_packer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [qbp_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                            req_last_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [qbp_pkg::WORD_W-1:0]           rsp_packed_word,
   output logic                                 rsp_last_word,
   input  wire logic                            csr_write,
   input  wire logic [qbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [qbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [qbp_pkg::BPV_W-1:0]    bits_per_value_ff, bits_per_value_in;
   logic                         big_endian_ff, big_endian_in;

   logic                         a_valid_ff, a_valid_in;
   logic [qbp_pkg::SAMPLE_W-1:0] a_sample_ff, a_sample_in;
   logic                         a_last_ff, a_last_in;

   logic                         go;
   logic [qbp_pkg::CODE_W-1:0]   code;
   logic [qbp_pkg::BPV_W-1:0]    width;

   qbp_pkg::push_type            push;
   qbp_pkg::pack_status_type     pack_status;
   qbp_pkg::fifo_status_type     fifo_status;
   qbp_pkg::entry_type           head;

   // Configuration register writes.
   always_comb begin
      bits_per_value_in = bits_per_value_ff;
      big_endian_in     = big_endian_ff;
      if (csr_write) begin
         unique case (csr_index)
            qbp_pkg::REG_BITS_PER_VALUE: bits_per_value_in = csr_wdata[qbp_pkg::BPV_W-1:0];
            qbp_pkg::REG_BIG_ENDIAN:     big_endian_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_per_value_ff <= qbp_pkg::BPV_RESET;
         big_endian_ff     <= 1'b0;
      end else begin
         bits_per_value_ff <= bits_per_value_in;
         big_endian_ff     <= big_endian_in;
      end
   end

   // The held item moves on when the queue has room for two words.
   always_comb begin
      go        = a_valid_ff && (fifo_status.count <= qbp_pkg::FIFO_CNT_W'(2));
      req_stall = a_valid_ff && !go;
   end

   // Input register.
   always_comb begin
      a_valid_in  = a_valid_ff;
      a_sample_in = a_sample_ff;
      a_last_in   = a_last_ff;
      if (!req_stall) begin
         a_valid_in  = req_valid;
         a_sample_in = req_sample;
         a_last_in   = req_last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff <= a_sample_in;
      a_last_ff   <= a_last_in;
   end

   qbp_quant u_quant (
      .sample         (a_sample_ff),
      .bits_per_value (bits_per_value_ff),
      .code           (code),
      .width          (width)
   );

   qbp_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .last       (a_last_ff),
      .code       (code),
      .width      (width),
      .big_endian (big_endian_ff),
      .push       (push),
      .status     (pack_status)
   );

   qbp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .status    (fifo_status)
   );

   assign rsp_packed_word = head.word;
   assign rsp_last_word   = head.last;

`ifndef SYNTH
   // The queue never holds more words than it has entries.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= qbp_pkg::FIFO_CNT_W'(qbp_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // A second word for one item only follows a first one.
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result word without a first");

   // The last sample of a stream leaves the accumulator empty.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (go && a_last_ff) |=> (pack_status.filled == '0))
      else $error("accumulator not cleared after last sample");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");
`endif

endmodule

`default_nettype wire

/* rtl/qbp_quant.sv */
// ----------------------------------------------------------------------------
// qbp_quant
// Clamps a fixed-point sample to zero..one and scales it to an n-bit code.
// ----------------------------------------------------------------------------
`default_nettype none

module qbp_quant (
   input  wire logic [qbp_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [qbp_pkg::BPV_W-1:0]    bits_per_value,
   output logic [qbp_pkg::CODE_W-1:0]        code,
   output logic [qbp_pkg::BPV_W-1:0]         width
);

   logic [qbp_pkg::CLAMP_W-1:0] clamped;
   logic [qbp_pkg::CODE_W:0]    max_wide;
   logic [qbp_pkg::CODE_W-1:0]  max_code;
   logic [qbp_pkg::PROD_W-1:0]  product;

   // Out-of-range code widths are held to the legal range.
   always_comb begin
      if (bits_per_value < qbp_pkg::BPV_MIN) begin
         width = qbp_pkg::BPV_MIN;
      end else if (bits_per_value > qbp_pkg::BPV_MAX) begin
         width = qbp_pkg::BPV_MAX;
      end else begin
         width = bits_per_value;
      end
   end

   // Negative samples go to zero and anything above one is held at one.
   always_comb begin
      if (sample[qbp_pkg::SAMPLE_W-1]) begin
         clamped = '0;
      end else if (sample > qbp_pkg::SAMPLE_W'(1 << qbp_pkg::FRAC_BITS)) begin
         clamped = qbp_pkg::CLAMP_W'(1 << qbp_pkg::FRAC_BITS);
      end else begin
         clamped = sample[qbp_pkg::CLAMP_W-1:0];
      end
   end

   // Scale by the largest code and drop the fraction bits.
   always_comb begin
      max_wide = ((qbp_pkg::CODE_W+1)'(1) << width) - (qbp_pkg::CODE_W+1)'(1);
      max_code = max_wide[qbp_pkg::CODE_W-1:0];
      product  = qbp_pkg::PROD_W'(clamped) * qbp_pkg::PROD_W'(max_code);
      code     = product[qbp_pkg::FRAC_BITS +: qbp_pkg::CODE_W];
   end

endmodule

`default_nettype wire

/* rtl/qbp_pack.sv */
// ----------------------------------------------------------------------------
// qbp_pack
// Bit accumulator: places each code at the lowest free bit and hands out
// completed and flushed words.
// ----------------------------------------------------------------------------
`default_nettype none

module qbp_pack (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         go,
   input  wire logic                         last,
   input  wire logic [qbp_pkg::CODE_W-1:0]   code,
   input  wire logic [qbp_pkg::BPV_W-1:0]    width,
   input  wire logic                         big_endian,
   output qbp_pkg::push_type                 push,
   output qbp_pkg::pack_status_type          status
);

   localparam int WIDE_W = qbp_pkg::WORD_W + qbp_pkg::CODE_W;

   logic [qbp_pkg::WORD_W-1:0]  partial_ff, partial_in;
   logic [qbp_pkg::FILL_W-1:0]  filled_ff, filled_in;

   logic [WIDE_W-1:0]           shifted;
   logic [qbp_pkg::WORD_W-1:0]  merged;
   logic [qbp_pkg::TOTAL_W-1:0] total;
   logic                        full;
   logic [qbp_pkg::WORD_W-1:0]  next_partial;
   logic [qbp_pkg::FILL_W-1:0]  next_filled;

   // Merge the code and work out what stays in the accumulator.
   always_comb begin
      shifted = WIDE_W'(code) << filled_ff;
      merged  = partial_ff | shifted[qbp_pkg::WORD_W-1:0];
      total   = qbp_pkg::TOTAL_W'(filled_ff) + qbp_pkg::TOTAL_W'(width);
      full    = total[qbp_pkg::TOTAL_W-1];
      if (full) begin
         next_partial = qbp_pkg::WORD_W'(shifted[WIDE_W-1:qbp_pkg::WORD_W]);
      end else begin
         next_partial = merged;
      end
      next_filled = total[qbp_pkg::FILL_W-1:0];
   end

   // Build the result words: a completed word first, then a flushed remainder.
   always_comb begin
      push = '0;
      if (go) begin
         if (full) begin
            push.push0       = 1'b1;
            push.entry0.word = qbp_pkg::order_word(merged, big_endian);
            push.entry0.last = last && (next_filled == '0);
            push.push1       = last && (next_filled != '0);
            push.entry1.word = qbp_pkg::order_word(next_partial, big_endian);
            push.entry1.last = 1'b1;
         end else begin
            push.push0       = last && (next_filled != '0);
            push.entry0.word = qbp_pkg::order_word(next_partial, big_endian);
            push.entry0.last = 1'b1;
         end
      end
   end

   // The last sample of a stream clears the accumulator.
   always_comb begin
      partial_in = partial_ff;
      filled_in  = filled_ff;
      if (go) begin
         if (last) begin
            partial_in = '0;
            filled_in  = '0;
         end else begin
            partial_in = next_partial;
            filled_in  = next_filled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         filled_ff  <= '0;
      end else begin
         partial_ff <= partial_in;
         filled_ff  <= filled_in;
      end
   end

   assign status.filled = filled_ff;

endmodule

`default_nettype wire

/* rtl/qbp_fifo.sv */
// ----------------------------------------------------------------------------
// qbp_fifo
// Four-entry result queue that takes up to two words per cycle and hands
// out one while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module qbp_fifo (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire qbp_pkg::push_type            push,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output qbp_pkg::entry_type                head,
   output qbp_pkg::fifo_status_type          status
);

   qbp_pkg::entry_type mem [qbp_pkg::FIFO_DEPTH];

   logic [qbp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [qbp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [qbp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [qbp_pkg::FIFO_PTR_W-1:0] wr_next;
   logic                           pop;

   // Pointer and count updates.
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_next   = wr_ptr_ff + qbp_pkg::FIFO_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + qbp_pkg::FIFO_PTR_W'(push.push0)
                            + qbp_pkg::FIFO_PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + qbp_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + qbp_pkg::FIFO_CNT_W'(push.push0)
                           + qbp_pkg::FIFO_CNT_W'(push.push1)
                           - qbp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem[wr_ptr_ff] <= push.entry0;
      end
      if (push.push1) begin
         mem[wr_next] <= push.entry1;
      end
   end

   assign rsp_valid    = (count_ff != '0);
   assign head         = mem[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

`default_nettype wire
